@@ hw/rtl/skcw_pkg.sv @@
package skcw_pkg;

   // Field widths of the transaction payloads.
   localparam int unsigned POS_FIELD_W = 16;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned INDEX_W     = 4;

   // Command codes carried by a request transaction.
   localparam logic CMD_TOKEN = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic               command;
      logic               is_keyword;
      logic [INDEX_W-1:0] keyword_index;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [POS_FIELD_W-1:0] best_start;
      logic [POS_FIELD_W-1:0] best_end;
      logic                   overflow;
   } rsp_type;

   // Per-cell control from the keyword decoder.
   typedef struct packed {
      logic clear;
      logic sel;
      logic last;
      logic first;
   } cell_ctrl_type;

   // Control handed from the cell stage to the best-window tracker.
   typedef struct packed {
      logic load;
      logic clear;
      logic hit;
      logic overflow;
   } best_ctrl_type;

endpackage

@@ hw/rtl/sequential_keyword_cover_window.sv @@
// Shortest window that covers a keyword sequence in order. Each request transaction
// carries one token already mapped to a keyword index (or marked as a non-keyword), or a
// clear command that starts a new paragraph; every request yields exactly one response
// transaction with the best window seen so far (found, start, end) and the position
// overflow flag. The block takes one transaction per clock cycle, back to back, while the
// response is not stalled. The accepting edge updates the row of keyword cells (one read of
// slot k-1 and one write of slot k, handed along the row) and the stage two register; once
// the response register is free, the candidate window is compared against the best one and
// the response register is loaded. Up to two transactions can be in flight while a response
// is stalled. No clearing pass is needed after reset. keyword_count must be written by the
// user on the csr port only while idle; the block itself does not enforce this.
module sequential_keyword_cover_window #(
   parameter int unsigned MAX_KEYWORDS  = 16,
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  skcw_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output skcw_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_enable,
   input  logic [skcw_pkg::COUNT_W-1:0]      csr_write_data
);

   localparam int unsigned LEN_W = POSITION_BITS + 1;
   localparam int unsigned CNT_W = $clog2(MAX_KEYWORDS + 1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // Configuration register: number of keywords in the required sequence.
   logic [skcw_pkg::COUNT_W-1:0] kw_count_ff;
   logic [31:0]                  kw_count_wide;
   logic [CNT_W-1:0]             eff_count;

   // Stage one state: position of the next token and the saturation flag.
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     ovf_ff, ovf_in;

   // Stage two pipeline register between the cells and the best-window tracker.
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_clear_ff;
   logic                     s2_hit_ff;
   logic                     s2_ovf_ff;
   logic [LEN_W-1:0]         s2_len_ff;
   logic [POSITION_BITS-1:0] s2_pos_ff;

   logic rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic do_clear;
   logic do_token;
   logic idx_in_range;
   logic rsp_ready;
   logic s2_take;
   logic any_hit;
   logic [LEN_W-1:0] cand_len;

   // Per-cell hand-off signals along the row.
   logic [POSITION_BITS-1:0] cell_pos   [MAX_KEYWORDS];
   logic [LEN_W-1:0]         cell_len   [MAX_KEYWORDS];
   logic                     cell_valid [MAX_KEYWORDS];
   logic [LEN_W-1:0]         cell_len_next [MAX_KEYWORDS];
   logic [MAX_KEYWORDS-1:0]  cell_hit;

   skcw_pkg::best_ctrl_type best_ctrl;

   // The configuration register takes every write; only the low five bits exist.
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_count_ff <= skcw_pkg::COUNT_W'(1);
      end else if (csr_write_enable) begin
         kw_count_ff <= csr_write_data;
      end
   end

   // A count of zero behaves as one, and counts beyond the row length are clamped.
   assign kw_count_wide = 32'(kw_count_ff);

   always_comb begin
      if (kw_count_wide == 32'd0) begin
         eff_count = CNT_W'(1);
      end else if (kw_count_wide > 32'(MAX_KEYWORDS)) begin
         eff_count = CNT_W'(MAX_KEYWORDS);
      end else begin
         eff_count = CNT_W'(kw_count_wide);
      end
   end

   // Handshake. The response register frees up when it is empty or being taken; the
   // stage two register then moves forward, and the input side accepts whenever stage
   // two can take a new transaction. One transaction per cycle flows unless rsp_stall holds.
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_take   = !s2_valid_ff || rsp_ready;
   assign req_stall = !s2_take;
   assign accept    = req_valid && s2_take;

   assign do_clear     = accept && (req_data.command == skcw_pkg::CMD_CLEAR);
   assign do_token     = accept && (req_data.command == skcw_pkg::CMD_TOKEN) && !ovf_ff;
   assign idx_in_range = 32'(req_data.keyword_index) < 32'(eff_count);

   // The row of keyword cells. Cell k sees the registered slot of cell k-1, so the
   // in-order extension of a window is a purely local step between neighbors.
   for (genvar k = 0; k < MAX_KEYWORDS; k++) begin : g_cell
      skcw_pkg::cell_ctrl_type  ctrl;
      logic [POSITION_BITS-1:0] prev_pos;
      logic [LEN_W-1:0]         prev_len;
      logic                     prev_valid;

      if (k == 0) begin : g_head
         assign prev_pos   = '0;
         assign prev_len   = '0;
         assign prev_valid = 1'b0;
      end else begin : g_link
         assign prev_pos   = cell_pos[k-1];
         assign prev_len   = cell_len[k-1];
         assign prev_valid = cell_valid[k-1];
      end

      always_comb begin
         ctrl.clear = do_clear;
         ctrl.sel   = do_token && req_data.is_keyword && idx_in_range
                      && (32'(req_data.keyword_index) == 32'(k));
         ctrl.last  = (32'(eff_count) == 32'(k + 1));
         ctrl.first = (k == 0);
      end

      skcw_cell #(
         .POSITION_BITS(POSITION_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cur_pos    (pos_ff),
         .prev_pos   (prev_pos),
         .prev_len   (prev_len),
         .prev_valid (prev_valid),
         .pos_q      (cell_pos[k]),
         .len_q      (cell_len[k]),
         .valid_q    (cell_valid[k]),
         .len_next   (cell_len_next[k]),
         .hit        (cell_hit[k])
      );
   end

   // At most one cell is selected per token, so the candidate is an AND-OR over the row.
   always_comb begin
      cand_len = '0;
      for (int k = 0; k < MAX_KEYWORDS; k++) begin
         cand_len = cand_len | (cell_len_next[k] & {LEN_W{cell_hit[k]}});
      end
   end

   assign any_hit = |cell_hit;

   // Every token uses one position. The token at the top position is processed, then
   // the counter holds and the overflow flag makes later tokens no-ops until a clear.
   always_comb begin
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (do_clear) begin
         pos_in = '0;
         ovf_in = 1'b0;
      end else if (do_token) begin
         if (pos_ff == POS_MAX) begin
            ovf_in = 1'b1;
         end else begin
            pos_in = pos_ff + POSITION_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
      end
   end

   // Stage two register.
   assign s2_valid_in = s2_take ? req_valid : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_clear_ff <= (req_data.command == skcw_pkg::CMD_CLEAR);
         s2_hit_ff   <= do_token && any_hit;
         s2_ovf_ff   <= ovf_in;
         s2_len_ff   <= cand_len;
         s2_pos_ff   <= pos_ff;
      end
   end

   // The best-window tracker loads when stage two moves into the response register.
   always_comb begin
      best_ctrl.load     = s2_valid_ff && rsp_ready;
      best_ctrl.clear    = s2_clear_ff;
      best_ctrl.hit      = s2_hit_ff;
      best_ctrl.overflow = s2_ovf_ff;
   end

   skcw_best #(
      .POSITION_BITS(POSITION_BITS)
   ) u_best (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (best_ctrl),
      .cand_len (s2_len_ff),
      .cand_pos (s2_pos_ff),
      .rsp_data (rsp_data)
   );

   assign rsp_valid_in = rsp_ready ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // Only one cell can complete a covering window on a given token.
   assert property (@(posedge clock) disable iff (reset) $onehot0(cell_hit))
      else $error("more than one keyword cell reports a covering window");

   // The overflow flag is only ever set with the counter parked at its top value.
   assert property (@(posedge clock) disable iff (reset) ovf_ff |-> (pos_ff == POS_MAX))
      else $error("overflow flag set below the top position");

   // A clear transaction restarts the position counter and drops the overflow flag.
   assert property (@(posedge clock) disable iff (reset)
      do_clear |=> (pos_ff == '0) && !ovf_ff)
      else $error("clear did not restart the position counter");

   // A clear in stage two never carries a candidate window.
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_clear_ff) |-> !s2_hit_ff)
      else $error("clear transaction carries a window candidate");

   // The input side only stalls when both pipeline registers are occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s2_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline has room");
`endif

endmodule

@@ hw/rtl/skcw_cell.sv @@
// One keyword slot: latest position and the shortest in-order window ending there.
module skcw_cell #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  skcw_pkg::cell_ctrl_type     ctrl,
   input  logic [POSITION_BITS-1:0]    cur_pos,
   input  logic [POSITION_BITS-1:0]    prev_pos,
   input  logic [POSITION_BITS:0]      prev_len,
   input  logic                        prev_valid,
   output logic [POSITION_BITS-1:0]    pos_q,
   output logic [POSITION_BITS:0]      len_q,
   output logic                        valid_q,
   output logic [POSITION_BITS:0]      len_next,
   output logic                        hit
);

   localparam int unsigned LEN_W = POSITION_BITS + 1;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic                     valid_ff, valid_in;
   logic [LEN_W-1:0]         ext_len;

   // Distance back to the previous keyword plus the window that ended there.
   assign ext_len = ({1'b0, cur_pos} - {1'b0, prev_pos}) + prev_len;

   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.sel) begin
         pos_in = cur_pos;
         if (ctrl.first) begin
            len_in   = LEN_W'(1);
            valid_in = 1'b1;
         end else if (prev_valid) begin
            len_in   = ext_len;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      len_ff <= len_in;
   end

   assign pos_q    = pos_ff;
   assign len_q    = len_ff;
   assign valid_q  = valid_ff;
   assign len_next = len_in;
   assign hit      = ctrl.sel & ctrl.last & valid_in;

endmodule

@@ hw/rtl/skcw_best.sv @@
// Best covering window so far; its registers are also the result payload.
module skcw_best #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  skcw_pkg::best_ctrl_type   ctrl,
   input  logic [POSITION_BITS:0]    cand_len,
   input  logic [POSITION_BITS-1:0]  cand_pos,
   output skcw_pkg::rsp_type         rsp_data
);

   localparam int unsigned LEN_W = POSITION_BITS + 1;

   logic [LEN_W-1:0]         best_len_ff, best_len_in;
   logic [POSITION_BITS-1:0] best_start_ff, best_start_in;
   logic [POSITION_BITS-1:0] best_end_ff, best_end_in;
   logic                     found_ff, found_in;
   logic                     overflow_ff, overflow_in;
   logic [LEN_W-1:0]         start_calc;
   logic [31:0]              start_wide;
   logic [31:0]              end_wide;

   // The window ends at the candidate token, so it begins len - 1 positions earlier.
   assign start_calc = ({1'b0, cand_pos} + LEN_W'(1)) - cand_len;

   always_comb begin
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      found_in      = found_ff;
      overflow_in   = overflow_ff;
      if (ctrl.load) begin
         overflow_in = ctrl.overflow;
         if (ctrl.clear) begin
            best_len_in   = '1;
            best_start_in = '0;
            best_end_in   = '0;
            found_in      = 1'b0;
         end else if (ctrl.hit && (cand_len < best_len_ff)) begin
            best_len_in   = cand_len;
            best_start_in = start_calc[POSITION_BITS-1:0];
            best_end_in   = cand_pos;
            found_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_len_ff   <= '1;
         best_start_ff <= '0;
         best_end_ff   <= '0;
         found_ff      <= 1'b0;
         overflow_ff   <= 1'b0;
      end else begin
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
         found_ff      <= found_in;
         overflow_ff   <= overflow_in;
      end
   end

   assign start_wide = 32'(best_start_ff);
   assign end_wide   = 32'(best_end_ff);

   always_comb begin
      rsp_data.found      = found_ff;
      rsp_data.best_start = start_wide[skcw_pkg::POS_FIELD_W-1:0];
      rsp_data.best_end   = end_wide[skcw_pkg::POS_FIELD_W-1:0];
      rsp_data.overflow   = overflow_ff;
   end

endmodule
